>>> src/rrgu_pkg.sv
// Package for the raster row to gray unpacker.
// Holds shared types, codes, limits and arithmetic helpers; depends on nothing.
package rrgu_pkg;

	localparam int MaxWidth  = 4096;
	localparam int MapLimit  = 768;
	localparam int QueueDepth = 2;

	localparam int WidthW = 13;   // row_width register
	localparam int MapW   = 10;   // map_bytes register
	localparam int ColW   = 12;   // column counter
	localparam int CfgW   = 13;   // widest register
	localparam int CfgIdxW = 2;

	typedef enum logic [1:0] {
		DEPTH_BIT  = 2'd0,
		DEPTH_BYTE = 2'd1,
		DEPTH_RGB  = 2'd2,
		DEPTH_NONE = 2'd3
	} depth_t;

	typedef enum logic [CfgIdxW-1:0] {
		REG_DEPTH = 2'd0,
		REG_WIDTH = 2'd1,
		REG_MAP   = 2'd2,
		REG_NONE  = 2'd3
	} reg_idx_t;

	// one queued word: a finished gray pixel or a packed 1-bit byte
	typedef struct packed {
		logic       restart;  // column restarts before first pixel
		logic       bitmap;   // value holds 8 one-bit pixels
		logic [7:0] value;
	} entry_t;

	// effective pixels per row
	function automatic logic [WidthW-1:0] row_len(input logic [1:0] depth,
		input logic [WidthW-1:0] width);
		logic [WidthW-1:0] w;
		begin
			w = width;
			if (w == '0) w = WidthW'(1);
			if (w > WidthW'(MaxWidth)) w = WidthW'(MaxWidth);
			if (depth == DEPTH_BIT) w = {w[WidthW-1:3], 3'b000};
			return w;
		end
	endfunction

	// x/10 for x < 1029 by reciprocal multiply
	function automatic logic [6:0] div10(input logic [9:0] x);
		logic [17:0] p;
		begin
			p = 18'(x) * 18'd205;
			return 7'(p >> 11);
		end
	endfunction

	// x/5 for x < 1024 by reciprocal multiply
	function automatic logic [7:0] div5(input logic [9:0] x);
		logic [17:0] p;
		begin
			p = 18'(x) * 18'd205;
			return 8'(p >> 10);
		end
	endfunction

endpackage

>>> src/rrgu_front.sv
// Front end of the unpacker: takes body bytes, skips colormap bytes,
// collects RGB triplets and pushes pixel words into the queue. Uses rrgu_pkg.
module rrgu_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    depth,
	input  logic [rrgu_pkg::WidthW-1:0]   width,
	input  logic [rrgu_pkg::MapW-1:0]     map_len,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [7:0]                    in_byte,
	input  logic                          in_first,
	input  logic                          q_full,
	output logic                          push,
	output rrgu_pkg::entry_t              push_entry
);

	logic [rrgu_pkg::MapW-1:0] skip_q;
	logic [1:0]                phase_q;
	logic [7:0]                red_q;
	logic [7:0]                green_q;
	logic                      restart_q;

	logic                      take;
	logic [rrgu_pkg::MapW-1:0] skip_now;
	logic [rrgu_pkg::MapW-1:0] map_eff;
	logic [1:0]                phase_now;
	logic [rrgu_pkg::WidthW-1:0] len;
	logic                      emit;
	logic                      is_bitmap;
	logic [7:0]                gray;

	assign in_ready = !q_full;
	assign take     = in_valid && in_ready;

	assign map_eff   = (map_len > rrgu_pkg::MapW'(rrgu_pkg::MapLimit)) ?
		rrgu_pkg::MapW'(rrgu_pkg::MapLimit) : map_len;
	assign skip_now  = in_first ? map_eff : skip_q;
	assign phase_now = in_first ? 2'd0 : phase_q;
	assign len       = rrgu_pkg::row_len(depth, width);

	// (3r)/10 + (3g)/5 + b/10
	always_comb begin
		logic [9:0] r3;
		logic [9:0] g3;
		r3 = {2'b00, red_q} + {1'b0, red_q, 1'b0};
		g3 = {2'b00, green_q} + {1'b0, green_q, 1'b0};
		gray = 8'(rrgu_pkg::div10(r3)) + rrgu_pkg::div5(g3)
			+ 8'(rrgu_pkg::div10({2'b00, in_byte}));
	end

	always_comb begin
		emit      = 1'b0;
		is_bitmap = 1'b0;
		if (skip_now == '0) begin
			case (depth)
				rrgu_pkg::DEPTH_BIT: begin
					emit      = (len != '0);
					is_bitmap = 1'b1;
				end
				rrgu_pkg::DEPTH_BYTE: emit = 1'b1;
				rrgu_pkg::DEPTH_RGB:  emit = (phase_now == 2'd2) || (phase_now == 2'd3);
				default:              emit = 1'b0;
			endcase
		end
	end

	assign push               = take && emit;
	assign push_entry.restart = restart_q || in_first;
	assign push_entry.bitmap  = is_bitmap;
	assign push_entry.value   = (depth == rrgu_pkg::DEPTH_RGB) ? gray : in_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q    <= '0;
			phase_q   <= '0;
			red_q     <= '0;
			green_q   <= '0;
			restart_q <= 1'b0;
		end else if (take) begin
			restart_q <= push ? 1'b0 : (restart_q || in_first);
			if (skip_now != '0) begin
				skip_q  <= skip_now - rrgu_pkg::MapW'(1);
				phase_q <= phase_now;
			end else begin
				skip_q <= skip_now;
				if (depth == rrgu_pkg::DEPTH_RGB) begin
					case (phase_now)
						2'd0: begin
							red_q   <= in_byte;
							phase_q <= 2'd1;
						end
						2'd1: begin
							green_q <= in_byte;
							phase_q <= 2'd2;
						end
						default: phase_q <= 2'd0;
					endcase
				end else begin
					phase_q <= phase_now;
				end
			end
		end
	end

endmodule

>>> src/rrgu_queue.sv
// Short queue of pixel words between front and back end.
// Register-based, two entries. Uses rrgu_pkg.
module rrgu_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  rrgu_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output rrgu_pkg::entry_t head
);

	localparam int PtrW = $clog2(rrgu_pkg::QueueDepth);
	localparam int CntW = $clog2(rrgu_pkg::QueueDepth + 1);

	rrgu_pkg::entry_t mem_q [rrgu_pkg::QueueDepth];
	logic [PtrW-1:0]  wr_q;
	logic [PtrW-1:0]  rd_q;
	logic [CntW-1:0]  cnt_q;

	assign full      = (cnt_q == CntW'(rrgu_pkg::QueueDepth));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PtrW'(rrgu_pkg::QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
			if (pop)  rd_q <= (rd_q == PtrW'(rrgu_pkg::QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CntW'(1);
				2'b01:   cnt_q <= cnt_q - CntW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

>>> src/rrgu_back.sv
// Back end of the unpacker: expands queued words into pixels, keeps the
// column counter and drives the output register. Uses rrgu_pkg.
module rrgu_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [1:0]                    depth,
	input  logic [rrgu_pkg::WidthW-1:0]   width,
	input  logic                          q_valid,
	input  rrgu_pkg::entry_t              q_head,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [7:0]                    out_gray,
	output logic [rrgu_pkg::ColW-1:0]     out_col,
	output logic                          out_row_end,
	output logic                          out_last
);

	logic [rrgu_pkg::ColW-1:0] col_q;
	logic [2:0]                bit_q;
	logic                      vld_q;
	logic [7:0]                gray_q;
	logic [rrgu_pkg::ColW-1:0] colo_q;
	logic                      end_q;
	logic                      last_q;

	logic                        load;
	logic [rrgu_pkg::WidthW-1:0] len;
	logic [rrgu_pkg::ColW-1:0]   c;
	logic                        row_end;
	logic                        word_last;
	logic [7:0]                  gray;

	assign load = q_valid && (!vld_q || out_ready);
	assign len  = rrgu_pkg::row_len(depth, width);

	always_comb begin
		c = (q_head.restart && bit_q == 3'd0) ? '0 : col_q;
		if ({1'b0, c} >= len) c = '0;
		row_end   = ({1'b0, c} == len - rrgu_pkg::WidthW'(1));
		word_last = !q_head.bitmap || (bit_q == 3'd7);
		if (q_head.bitmap)
			gray = q_head.value[3'd7 - bit_q] ? 8'h00 : 8'hFF;
		else
			gray = q_head.value;
	end

	assign pop = load && word_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			bit_q <= '0;
			vld_q <= 1'b0;
		end else begin
			if (load) begin
				col_q <= row_end ? '0 : c + rrgu_pkg::ColW'(1);
				bit_q <= word_last ? 3'd0 : bit_q + 3'd1;
				vld_q <= 1'b1;
			end else if (out_ready) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			gray_q <= gray;
			colo_q <= c;
			end_q  <= row_end;
			last_q <= word_last;
		end
	end

	assign out_valid   = vld_q;
	assign out_gray    = gray_q;
	assign out_col     = colo_q;
	assign out_row_end = end_q;
	assign out_last    = last_q;

endmodule

>>> src/raster_row_to_gray_unpacker.sv
// Top level of the raster row to gray unpacker.
// Holds the configuration registers and ties front end, queue and back end.
// Depends on rrgu_pkg, rrgu_front, rrgu_queue, rrgu_back.
//
// Usage:
//   s_* stream: one body byte per word; s_tuser marks the first body byte
//     of a slice, which reloads the colormap skip count and clears the
//     column and RGB phase.
//   m_* stream: one gray pixel per word; m_tlast marks the final pixel
//     produced by one input byte.
//   cfg port: write depth_mode (0), row_width (1), map_bytes (2) while idle.
// Path: each byte that yields pixels enters the queue, and its pixels are then
//   loaded from the queue head into the output register that drives m_tvalid.
// Throughput: 1-bit mode gives one pixel per cycle, stepping the back end's
//   bit index counter; 8-bit mode takes one byte per cycle, RGB one byte
//   per cycle (one pixel per 3); all while m_tready is high.
// Reset: depth 8-bit, width 256, no colormap skip, queue and output empty.
// Stall: with m_tready low the output word holds, the back end stops and
//   the two-entry queue fills; s_tready drops once it is full.
module raster_row_to_gray_unpacker (
	input  logic                           clk,
	input  logic                           arst_n,
	// config write port
	input  logic                           cfg_we,
	input  logic [rrgu_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [rrgu_pkg::CfgW-1:0]      cfg_data,
	// input bytes
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] data_byte
	input  logic                           s_tuser,   // [0] first_of_slice
	// output pixels
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata,   // [7:0] gray_pixel,
	                                                  // [19:8] column,
	                                                  // [20] row_end, rest 0
	output logic                           m_tlast    // last
);

	logic [1:0]                  depth_q;
	logic [rrgu_pkg::WidthW-1:0] width_q;
	logic [rrgu_pkg::MapW-1:0]   map_q;

	// configuration registers; the user writes them only while idle, not enforced here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= rrgu_pkg::DEPTH_BYTE;
			width_q <= rrgu_pkg::WidthW'(256);
			map_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				rrgu_pkg::REG_DEPTH: depth_q <= cfg_data[1:0];
				rrgu_pkg::REG_WIDTH: width_q <= cfg_data[rrgu_pkg::WidthW-1:0];
				rrgu_pkg::REG_MAP:   map_q   <= cfg_data[rrgu_pkg::MapW-1:0];
				default: ;
			endcase
		end
	end

	logic             push;
	rrgu_pkg::entry_t push_entry;
	logic             q_full;
	logic             pop;
	logic             q_valid;
	rrgu_pkg::entry_t q_head;

	logic [7:0]                gray;
	logic [rrgu_pkg::ColW-1:0] col;
	logic                      row_end;

	rrgu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.depth      (depth_q),
		.width      (width_q),
		.map_len    (map_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_first   (s_tuser),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	rrgu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.not_empty  (q_valid),
		.head       (q_head)
	);

	rrgu_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.depth       (depth_q),
		.width       (width_q),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_gray    (gray),
		.out_col     (col),
		.out_row_end (row_end),
		.out_last    (m_tlast)
	);

	assign m_tdata = {3'b000, row_end, col, gray};

endmodule

>>> tb/testbench.sv
// Self-checking bench for raster_row_to_gray_unpacker: byte stream in, gray pixels out.
// Predicts each pixel word from its own copy of the unpacker state and checks every field.
// Depends on rrgu_pkg and the raster_row_to_gray_unpacker RTL.
module testbench;

	localparam int IdleLimit   = 1000;  // cycles with no word moving on either side
	localparam int SettleWait  = 20;    // cycles after the last pixel before touching config
	localparam int RandomBytes = 180;

	// one body byte as offered on the input stream
	typedef struct {
		logic [7:0] data;
		logic       first;
	} raw_byte_t;

	// one predicted output word
	typedef struct {
		logic [7:0]  gray;
		logic [11:0] column;
		logic        row_end;
		logic        last;
	} gray_word_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we = 1'b0;
	logic [rrgu_pkg::CfgIdxW-1:0]  cfg_index = '0;
	logic [rrgu_pkg::CfgW-1:0]     cfg_data = '0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [7:0]                    s_tdata = '0;
	logic                          s_tuser = 1'b0;
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [23:0]                   m_tdata;
	logic                          m_tlast;

	raster_row_to_gray_unpacker i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: config shadow plus unpacker state, all at block widths
	// ------------------------------------------------------------------
	rrgu_pkg::depth_t cfg_depth = rrgu_pkg::DEPTH_BYTE;
	logic [12:0]  cfg_width = 13'd256;
	logic [9:0]   cfg_map = '0;

	logic [9:0]   skip_left = '0;    // colormap bytes still to drop
	logic [11:0]  col_next = '0;     // column of the next pixel
	logic [1:0]   rgb_phase = '0;    // 0 red, 1 green, 2 blue next
	logic [7:0]   red_held = '0;
	logic [7:0]   green_held = '0;

	raw_byte_t    pending_bytes[$];  // words the sender still has to offer
	gray_word_t   expected_pixels[$];
	int           mismatch_count = 0;

	// Places one pixel on the row; a column left past the row end
	// (width or depth changed mid-row) wraps to 0 first.
	function automatic gray_word_t place_pixel(input logic [7:0] g, input logic [12:0] len);
		gray_word_t w;
		if ({1'b0, col_next} >= len)
			col_next = '0;
		w.gray    = g;
		w.column  = col_next;
		w.row_end = ({1'b0, col_next} == len - 13'd1);
		w.last    = 1'b0;
		col_next  = w.row_end ? 12'd0 : col_next + 12'd1;
		return w;
	endfunction

	// Works out the pixels one accepted byte gives and queues them.
	task automatic unpack_to_gray(input raw_byte_t b);
		gray_word_t  burst[$];
		logic [12:0] len;
		int          mix;
		if (b.first) begin
			// slice start: reload skip, clear column and color phase
			skip_left = (cfg_map > 10'(rrgu_pkg::MapLimit)) ?
				10'(rrgu_pkg::MapLimit) : cfg_map;
			col_next  = '0;
			rgb_phase = '0;
		end
		if (skip_left != '0) begin
			skip_left = skip_left - 10'd1;
			return;
		end
		len = cfg_width;
		if (len == '0)
			len = 13'd1;
		if (len > 13'(rrgu_pkg::MaxWidth))
			len = 13'(rrgu_pkg::MaxWidth);
		if (cfg_depth == rrgu_pkg::DEPTH_BIT)
			len[2:0] = 3'b000;
		case (cfg_depth)
			rrgu_pkg::DEPTH_BIT: begin
				// rows under 8 pixels hold no byte: nothing comes out
				if (len != '0) begin
					for (int i = 7; i >= 0; i--)
						burst.push_back(place_pixel(b.data[i] ? 8'h00 : 8'hFF, len));
				end
			end
			rrgu_pkg::DEPTH_BYTE: burst.push_back(place_pixel(b.data, len));
			rrgu_pkg::DEPTH_RGB: begin
				case (rgb_phase)
					2'd0: begin
						red_held  = b.data;
						rgb_phase = 2'd1;
					end
					2'd1: begin
						green_held = b.data;
						rgb_phase  = 2'd2;
					end
					default: begin
						mix = (3 * int'(red_held)) / 10 + (3 * int'(green_held)) / 5
							+ int'(b.data) / 10;
						burst.push_back(place_pixel(8'(mix), len));
						rgb_phase = 2'd0;
					end
				endcase
			end
			default: ;  // unused depth code swallows the byte
		endcase
		if (burst.size() != 0)
			burst[burst.size() - 1].last = 1'b1;
		foreach (burst[i])
			expected_pixels.push_back(burst[i]);
	endtask

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%t: %s", $realtime, msg);
	endtask

	// ------------------------------------------------------------------
	// Sender: bursts of words with random gaps, fed from pending_bytes
	// ------------------------------------------------------------------
	bit  offer_open = 1'b0;  // a word is on the bus and not yet taken
	bit  tx_gappy = 1'b1;
	int  burst_left = 0;
	int  gap_left = 0;

	// acceptance is seen at the rising edge, where the predictor runs
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			unpack_to_gray(pending_bytes.pop_front());
			offer_open = 1'b0;
			if (burst_left > 0)
				burst_left--;
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 16);
				if (!tx_gappy || $urandom_range(0, 3) == 0)
					gap_left = 0;
				else
					gap_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 24 : 4);
			end
		end
	end

	// valid holds until taken; new words and gaps start on the falling edge
	always @(negedge clk) begin
		if (!offer_open) begin
			if (gap_left == 0 && pending_bytes.size() != 0) begin
				s_tvalid   <= 1'b1;
				s_tdata    <= pending_bytes[0].data;
				s_tuser    <= pending_bytes[0].first;
				offer_open = 1'b1;
			end else begin
				if (gap_left != 0)
					gap_left--;
				s_tvalid <= 1'b0;
				s_tdata  <= 8'($urandom);
				s_tuser  <= 1'($urandom);
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: ready follows a random bit pattern redrawn each period
	// ------------------------------------------------------------------
	int          rx_mode = 0;  // 0 always ready, 1 light stalls, 2 heavy stalls
	logic [15:0] ready_bits = '1;
	logic [3:0]  ready_idx = '0;

	always @(negedge clk) begin
		if (ready_idx == '0) begin
			case (rx_mode)
				0: ready_bits = '1;
				1: ready_bits = 16'($urandom | $urandom);
				default: ready_bits = 16'($urandom & $urandom);
			endcase
		end
		m_tready  <= ready_bits[ready_idx];
		ready_idx = ready_idx + 4'd1;
	end

	// ------------------------------------------------------------------
	// Monitor: each output word against the oldest prediction
	// ------------------------------------------------------------------
	always @(posedge clk) begin : pixel_monitor
		gray_word_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_pixels.size() == 0) begin
				flag_error($sformatf("unexpected word: tdata %h tlast %b", m_tdata, m_tlast));
			end else begin
				want = expected_pixels.pop_front();
				if (m_tdata[7:0] !== want.gray || m_tdata[19:8] !== want.column
					|| m_tdata[20] !== want.row_end || m_tlast !== want.last
					|| m_tdata[23:21] !== 3'b000)
					flag_error($sformatf({"pixel mismatch: exp gray %0d col %0d end %b last %b",
						", got gray %0d col %0d end %b last %b pad %b"},
						want.gray, want.column, want.row_end, want.last,
						m_tdata[7:0], m_tdata[19:8], m_tdata[20], m_tlast, m_tdata[23:21]));
			end
		end
	end

	// Watchdog: a stuck handshake on both sides ends the run
	int idle_cycles = 0;

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IdleLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	task automatic queue_byte(input logic [7:0] data, input logic first);
		raw_byte_t b;
		b.data  = data;
		b.first = first;
		pending_bytes.push_back(b);
	endtask

	// config shadow follows the write at once; the block is idle here
	task automatic write_reg(input rrgu_pkg::reg_idx_t idx,
		input logic [rrgu_pkg::CfgW-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			rrgu_pkg::REG_DEPTH: cfg_depth = rrgu_pkg::depth_t'(value[1:0]);
			rrgu_pkg::REG_WIDTH: cfg_width = value[12:0];
			rrgu_pkg::REG_MAP:   cfg_map   = value[9:0];
			default:   ;
		endcase
	endtask

	task automatic set_config(input rrgu_pkg::depth_t depth, input logic [12:0] width,
		input logic [9:0] map);
		write_reg(rrgu_pkg::REG_DEPTH, rrgu_pkg::CfgW'(depth));
		write_reg(rrgu_pkg::REG_WIDTH, rrgu_pkg::CfgW'(width));
		write_reg(rrgu_pkg::REG_MAP, rrgu_pkg::CfgW'(map));
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Waits for every word to go in and every pixel to come out, then lets
	// the pipeline settle: skipped bytes leave no pixel to wait on.
	task automatic drain();
		while (pending_bytes.size() != 0 || offer_open || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SettleWait) @(posedge clk);
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		int               counted;
		int               slices;
		int               len_bytes;
		int               pick;
		rrgu_pkg::depth_t depth;
		logic [12:0]      width;
		logic [9:0]       map;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// reset defaults: 8-bit, width 256, no skip
		rx_mode = 1;
		queue_byte(8'h00, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hA5, 1'b0);
		drain();

		// row narrowed under the running column: wraps to 0;
		// the unused register index must change nothing
		write_reg(rrgu_pkg::REG_NONE, '1);
		set_config(rrgu_pkg::DEPTH_BYTE, 13'd2, 10'd0);
		queue_byte(8'h3C, 1'b0);
		queue_byte(8'hC3, 1'b0);
		drain();

		// 1-bit rows of 8 with two colormap bytes in front
		rx_mode = 2;
		set_config(rrgu_pkg::DEPTH_BIT, 13'd8, 10'd2);
		queue_byte(8'h11, 1'b1);
		queue_byte(8'h22, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h5A, 1'b0);
		drain();

		// RGB extremes, zero width counts as one; ends with red held
		rx_mode = 0;
		set_config(rrgu_pkg::DEPTH_RGB, 13'd0, 10'd0);
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h80, 1'b0);
		drain();

		// depth change keeps the RGB phase and held red; width over the max
		set_config(rrgu_pkg::DEPTH_BYTE, 13'h1FFF, 10'd0);
		queue_byte(8'h01, 1'b0);
		drain();
		set_config(rrgu_pkg::DEPTH_RGB, 13'h1FFF, 10'd0);
		queue_byte(8'h40, 1'b0);
		queue_byte(8'h20, 1'b0);
		drain();

		// narrow 1-bit rows and the unused depth: no pixels at all
		set_config(rrgu_pkg::DEPTH_BIT, 13'd7, 10'd0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		drain();
		set_config(rrgu_pkg::DEPTH_NONE, 13'd16, 10'd0);
		queue_byte(8'h12, 1'b1);
		drain();

		// --- random slices, a fresh setting per phase ---
		counted = 0;
		while (counted < RandomBytes) begin
			pick = $urandom_range(0, 19);
			depth = (pick < 7) ? rrgu_pkg::DEPTH_BIT : (pick < 12) ? rrgu_pkg::DEPTH_BYTE :
				(pick < 19) ? rrgu_pkg::DEPTH_RGB : rrgu_pkg::DEPTH_NONE;
			case ($urandom_range(0, 9))
				0: width = 13'd0;
				1: width = 13'(rrgu_pkg::MaxWidth);
				2: width = 13'($urandom_range(rrgu_pkg::MaxWidth + 1, 8191));
				3: width = 13'($urandom_range(1, 7));
				default: width = 13'($urandom_range(1, 40));
			endcase
			if ($urandom_range(0, 7) == 0)
				map = 10'($urandom_range(0, 20));
			else
				map = $urandom_range(0, 1) ? 10'd0 : 10'($urandom_range(1, 3));
			set_config(depth, width, map);
			rx_mode  = $urandom_range(0, 2);
			tx_gappy = ($urandom_range(0, 3) != 0);

			slices = $urandom_range(1, 3);
			for (int s = 0; s < slices; s++) begin
				len_bytes = $urandom_range(3, 24);
				// mostly clean slices; now and then one continues without
				// a start mark or restarts in the middle
				queue_byte(rand_byte(), ($urandom_range(0, 5) != 0));
				for (int k = 1; k < len_bytes; k++)
					queue_byte(rand_byte(), ($urandom_range(0, 29) == 0));
				if (!(depth == rrgu_pkg::DEPTH_NONE ||
					(depth == rrgu_pkg::DEPTH_BIT && width < 13'd8)))
					counted += len_bytes;
			end
			drain();
		end

		if (mismatch_count == 0 && expected_pixels.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

>>> filelist.f
src/rrgu_pkg.sv
src/rrgu_front.sv
src/rrgu_queue.sv
src/rrgu_back.sv
src/raster_row_to_gray_unpacker.sv
tb/testbench.sv
